>>> sv/gpps_pkg.sv
// ----------------------------------------------------------------------------
// gpps_pkg
// shared types and constants for the goldbach prime pair split core
// ----------------------------------------------------------------------------
`default_nettype none

package gpps_pkg;

    localparam int NUM_WIDTH_DEF = 16;

    // first trial divisor and its square
    localparam int FIRST_DIV    = 5;
    localparam int FIRST_DIV_SQ = 25;
    localparam int SMALL_DIV    = 3;
    localparam int DIV_STEP     = 6;

    typedef struct packed {
        logic done;
        logic zero;
    } t_mod_rsp;

    typedef struct packed {
        logic done;
        logic is_prime;
    } t_pt_rsp;

endpackage

`default_nettype wire

>>> sv/goldbach_prime_pair_split_core.sv
// run time is data dependent; each remainder runs on the shared remainder unit
// a primality test of v costs up to 2*(sqrt(v)/6+1)+1 remainders, up to two tests
// per candidate; odd n with no pair walks every candidate up to n/2
// throughput: one request at a time, the next is taken once the result is registered
// reset: synchronous active low, clears the sequencers and the output valid
// ----------------------------------------------------------------------------
// goldbach_prime_pair_split_core
// splits n into primes p + q, p <= q, trying p = 2, 3, then 6k-1 / 6k+1
// ----------------------------------------------------------------------------
`default_nettype none

module goldbach_prime_pair_split_core #(
    parameter int NUM_WIDTH  = gpps_pkg::NUM_WIDTH_DEF,
    parameter int IN_TDATA_W  = ((NUM_WIDTH + 7) / 8) * 8,
    parameter int OUT_TDATA_W = ((2 * NUM_WIDTH + 1 + 7) / 8) * 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,   // n
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata    // found, small_prime, large_prime
);
    import gpps_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CAND = 3'd1;
    localparam logic [2:0] S_TP   = 3'd2;
    localparam logic [2:0] S_TQ   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]           r_state;
    logic [NUM_WIDTH-1:0] r_n;
    logic [NUM_WIDTH-1:0] r_p;
    logic [NUM_WIDTH-1:0] r_q;
    logic                 r_add4;
    logic                 r_hit;
    logic                 r_pt_start;
    logic [NUM_WIDTH-1:0] r_pt_value;
    logic                 r_ovalid;
    logic                 r_found;
    logic [NUM_WIDTH-1:0] r_small;
    logic [NUM_WIDTH-1:0] r_large;
    logic [NUM_WIDTH-1:0] n_p;
    t_pt_rsp              w_pt_rsp;

    gpps_prime_test #(.NUM_WIDTH(NUM_WIDTH)) u_pt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_pt_start),
        .i_value (r_pt_value),
        .o_rsp   (w_pt_rsp)
    );

    always_comb begin
        if (r_p == NUM_WIDTH'(2)) begin
            n_p = NUM_WIDTH'(3);
        end else if (r_p == NUM_WIDTH'(3)) begin
            n_p = NUM_WIDTH'(FIRST_DIV);
        end else if (r_add4) begin
            n_p = r_p + NUM_WIDTH'(4);
        end else begin
            n_p = r_p + NUM_WIDTH'(2);
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pt_start <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_pt_start <= 1'b0;
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_n     <= i_s_tdata[NUM_WIDTH-1:0];
                        r_p     <= NUM_WIDTH'(2);
                        r_add4  <= 1'b0;
                        r_state <= S_CAND;
                    end
                end
                S_CAND: begin
                    if ({r_p, 1'b0} > {1'b0, r_n}) begin
                        r_hit   <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_q        <= r_n - r_p;
                        r_pt_value <= r_p;
                        r_pt_start <= 1'b1;
                        r_state    <= S_TP;
                    end
                end
                S_TP: begin
                    if (w_pt_rsp.done) begin
                        if (w_pt_rsp.is_prime) begin
                            r_pt_value <= r_q;
                            r_pt_start <= 1'b1;
                            r_state    <= S_TQ;
                        end else begin
                            r_p     <= n_p;
                            r_add4  <= (r_p > NUM_WIDTH'(3)) && !r_add4;
                            r_state <= S_CAND;
                        end
                    end
                end
                S_TQ: begin
                    if (w_pt_rsp.done) begin
                        if (w_pt_rsp.is_prime) begin
                            r_hit   <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_p     <= n_p;
                            r_add4  <= (r_p > NUM_WIDTH'(3)) && !r_add4;
                            r_state <= S_CAND;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ovalid || i_m_tready)) begin
            r_found <= r_hit;
            r_small <= r_hit ? r_p : '0;
            r_large <= r_hit ? r_q : '0;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = OUT_TDATA_W'({r_large, r_small, r_found});

endmodule

`default_nettype wire

>>> sv/gpps_mod_unit.sv
// ----------------------------------------------------------------------------
// gpps_mod_unit
// restoring remainder unit, one dividend bit per cycle, flags a zero remainder
// ----------------------------------------------------------------------------
`default_nettype none

module gpps_mod_unit #(
    parameter int NUM_WIDTH = gpps_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [NUM_WIDTH-1:0] i_dividend,
    input  wire logic [NUM_WIDTH-1:0] i_divisor,
    output gpps_pkg::t_mod_rsp        o_rsp
);
    import gpps_pkg::*;

    localparam int CNT_W = $clog2(NUM_WIDTH + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [NUM_WIDTH-1:0] r_rem;
    logic [NUM_WIDTH-1:0] r_dvd;
    logic [NUM_WIDTH-1:0] r_div;
    logic [NUM_WIDTH:0]   w_trial;
    logic [NUM_WIDTH-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[NUM_WIDTH-1]};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = NUM_WIDTH'(w_trial - {1'b0, r_div});
        end else begin
            n_rem = w_trial[NUM_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[NUM_WIDTH-2:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.zero = (r_rem == '0);

endmodule

`default_nettype wire

>>> sv/gpps_prime_test.sv
// ----------------------------------------------------------------------------
// gpps_prime_test
// trial division sequencer over 3 and then 6k-1 / 6k+1 divisors on the shared remainder unit
// ----------------------------------------------------------------------------
`default_nettype none

module gpps_prime_test #(
    parameter int NUM_WIDTH = gpps_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [NUM_WIDTH-1:0] i_value,
    output gpps_pkg::t_pt_rsp         o_rsp
);
    import gpps_pkg::*;

    localparam int DSQ_W = NUM_WIDTH + 4;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_M3   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_MA   = 3'd3;
    localparam logic [2:0] S_MB   = 3'd4;

    logic [2:0]           r_state;
    logic [NUM_WIDTH-1:0] r_val;
    logic [NUM_WIDTH-1:0] r_d;
    logic [DSQ_W-1:0]     r_dsq;
    logic                 r_done;
    logic                 r_prime;
    logic                 r_mstart;
    logic [NUM_WIDTH-1:0] r_mdiv;
    t_mod_rsp             w_mrsp;
    logic [DSQ_W-1:0]     w_d_ext;

    assign w_d_ext = DSQ_W'(r_d);

    gpps_mod_unit #(.NUM_WIDTH(NUM_WIDTH)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_mstart),
        .i_dividend (r_val),
        .i_divisor  (r_mdiv),
        .o_rsp      (w_mrsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_mstart <= 1'b0;
        end else begin
            r_done   <= 1'b0;
            r_mstart <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_val <= i_value;
                        if (i_value == NUM_WIDTH'(2) || i_value == NUM_WIDTH'(3)) begin
                            r_prime <= 1'b1;
                            r_done  <= 1'b1;
                        end else if (i_value < NUM_WIDTH'(2) || !i_value[0]) begin
                            r_prime <= 1'b0;
                            r_done  <= 1'b1;
                        end else begin
                            r_mdiv   <= NUM_WIDTH'(SMALL_DIV);
                            r_mstart <= 1'b1;
                            r_state  <= S_M3;
                        end
                    end
                end
                S_M3: begin
                    if (w_mrsp.done) begin
                        if (w_mrsp.zero) begin
                            r_prime <= 1'b0;
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_d     <= NUM_WIDTH'(FIRST_DIV);
                            r_dsq   <= DSQ_W'(FIRST_DIV_SQ);
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    if (r_dsq > DSQ_W'(r_val)) begin
                        r_prime <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_mdiv   <= r_d;
                        r_mstart <= 1'b1;
                        r_state  <= S_MA;
                    end
                end
                S_MA: begin
                    if (w_mrsp.done) begin
                        if (w_mrsp.zero) begin
                            r_prime <= 1'b0;
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_mdiv   <= r_d + NUM_WIDTH'(2);
                            r_mstart <= 1'b1;
                            r_state  <= S_MB;
                        end
                    end
                end
                S_MB: begin
                    if (w_mrsp.done) begin
                        if (w_mrsp.zero) begin
                            r_prime <= 1'b0;
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            // (d+6)^2 = d^2 + 12d + 36
                            r_dsq   <= r_dsq + (w_d_ext << 3) + (w_d_ext << 2)
                                       + DSQ_W'(DIV_STEP * DIV_STEP);
                            r_d     <= r_d + NUM_WIDTH'(DIV_STEP);
                            r_state <= S_CHK;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.is_prime = r_prime;

endmodule

`default_nettype wire

>>> sv/gpps_checker.sv
// ----------------------------------------------------------------------------
// gpps_checker
// port level checks of the goldbach prime pair split core, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

module gpps_checker #(
    parameter int NUM_WIDTH  = gpps_pkg::NUM_WIDTH_DEF,
    parameter int OUT_TDATA_W = ((2 * NUM_WIDTH + 1 + 7) / 8) * 8
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_tvalid,
    input wire logic                   o_s_tready,
    input wire logic                   o_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_tdata
);
    import gpps_pkg::*;

    logic                 w_found;
    logic [NUM_WIDTH-1:0] w_small;
    logic [NUM_WIDTH-1:0] w_large;

    assign w_found = o_m_tdata[0];
    assign w_small = o_m_tdata[NUM_WIDTH:1];
    assign w_large = o_m_tdata[2*NUM_WIDTH:NUM_WIDTH+1];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("ready right after a request");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !w_found |-> o_m_tdata == '0)
        else $error("miss with nonzero primes");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_found |-> w_small <= w_large)
        else $error("small prime above large prime");

    a_min_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_found |-> w_small >= NUM_WIDTH'(2) && w_large >= NUM_WIDTH'(2))
        else $error("prime below two");

endmodule

bind goldbach_prime_pair_split_core gpps_checker #(
    .NUM_WIDTH   (NUM_WIDTH),
    .OUT_TDATA_W (OUT_TDATA_W)
) u_gpps_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
